// ===== src/sgn_pkg.sv =====
// Shared types, constants and the sine table for the seeded gradient noise block.
`timescale 1ns / 1ps
package sgn_pkg;

  // Pipeline depth: one stage enable for each register stage.
  localparam int unsigned NUM_STAGES = 12;
  typedef logic [NUM_STAGES:1] stage_en_t;

  // Default formats of the coordinate and the result.
  localparam int unsigned COORD_FRAC_BITS_DEF = 16;
  localparam int unsigned OUT_FRAC_BITS_DEF   = 14;

  // Hash multipliers; the seed multiplier is the low word of the 64-bit constant.
  localparam logic [31:0] HASH_KX   = 32'd374761393;
  localparam logic [31:0] HASH_KY   = 32'd668265263;
  localparam logic [31:0] HASH_KS   = 32'hF767814F;
  localparam logic [31:0] HASH_KMIX = 32'd1274126177;

  // Seed after reset and its product with the seed multiplier.
  localparam logic [31:0] SEED_RESET     = 32'd123456789;
  localparam logic [63:0] SEED_MIX_WIDE  = 64'(SEED_RESET) * 64'(HASH_KS);
  localparam logic [31:0] SEED_MIX_RESET = SEED_MIX_WIDE[31:0];

  // Per-corner hash offsets: corner + 1 along x or y adds one multiplier.
  localparam logic [31:0] CORNER_OFS [4] = '{
    32'd0, HASH_KX, HASH_KY, 32'(HASH_KX + HASH_KY)
  };

  // Reduction modulo 45 by reciprocal multiplication.
  localparam logic [13:0] MOD45_RECIP = 14'd11651;
  localparam int unsigned MOD45_SHIFT = 19;

  // Fade polynomial constants in Q.16.
  localparam logic signed [20:0] FADE_C15 = 21'sd983040;
  localparam logic signed [20:0] FADE_C10 = 21'sd655360;

  // Unit offset in Q.16 and the dot product rounding term in Q.30.
  localparam logic signed [17:0] ONE_Q16   = 18'sd65536;
  localparam logic signed [34:0] DOT_ROUND = 35'sd8192;

  // round(sin(k degrees) * 16384) for k = 0..90.
  localparam logic signed [15:0] QSIN [91] = '{
    16'sd0, 16'sd286, 16'sd572, 16'sd857, 16'sd1143, 16'sd1428, 16'sd1713, 16'sd1997,
    16'sd2280, 16'sd2563, 16'sd2845, 16'sd3126, 16'sd3406, 16'sd3686, 16'sd3964,
    16'sd4240, 16'sd4516, 16'sd4790, 16'sd5063, 16'sd5334, 16'sd5604, 16'sd5872,
    16'sd6138, 16'sd6402, 16'sd6664, 16'sd6924, 16'sd7182, 16'sd7438, 16'sd7692,
    16'sd7943, 16'sd8192, 16'sd8438, 16'sd8682, 16'sd8923, 16'sd9162, 16'sd9397,
    16'sd9630, 16'sd9860, 16'sd10087, 16'sd10311, 16'sd10531, 16'sd10749, 16'sd10963,
    16'sd11174, 16'sd11381, 16'sd11585, 16'sd11786, 16'sd11982, 16'sd12176, 16'sd12365,
    16'sd12551, 16'sd12733, 16'sd12911, 16'sd13085, 16'sd13255, 16'sd13421, 16'sd13583,
    16'sd13741, 16'sd13894, 16'sd14044, 16'sd14189, 16'sd14330, 16'sd14466, 16'sd14598,
    16'sd14726, 16'sd14849, 16'sd14968, 16'sd15082, 16'sd15191, 16'sd15296, 16'sd15396,
    16'sd15491, 16'sd15582, 16'sd15668, 16'sd15749, 16'sd15826, 16'sd15897, 16'sd15964,
    16'sd16026, 16'sd16083, 16'sd16135, 16'sd16182, 16'sd16225, 16'sd16262, 16'sd16294,
    16'sd16322, 16'sd16344, 16'sd16362, 16'sd16374, 16'sd16382, 16'sd16384
  };

  // Sine of a whole-degree angle below 360, in Q2.14, folded onto the quarter table.
  function automatic logic signed [15:0] sin_deg(input logic [8:0] d);
    logic [8:0] idx;
    logic       neg;
    begin
      if (d <= 9'd90) begin
        idx = d;
        neg = 1'b0;
      end else if (d <= 9'd180) begin
        idx = 9'd180 - d;
        neg = 1'b0;
      end else if (d <= 9'd270) begin
        idx = d - 9'd180;
        neg = 1'b1;
      end else begin
        idx = 9'd360 - d;
        neg = 1'b1;
      end
      sin_deg = neg ? -QSIN[idx[6:0]] : QSIN[idx[6:0]];
    end
  endfunction

endpackage

// ===== src/sgn_fade.sv =====
// Quintic fade weight 6u^5 - 15u^4 + 10u^3 in Q1.16, three pipeline stages.
`timescale 1ns / 1ps
module sgn_fade (
  input  logic              clk_i,
  input  sgn_pkg::stage_en_t en_i,
  input  logic [15:0]       u_i,
  output logic [16:0]       w_o
);
  import sgn_pkg::*;

  logic signed [20:0] k6;
  logic signed [37:0] p_d;
  logic [31:0]        uu;
  logic signed [20:0] a_d;
  logic [31:0]        t3w;
  logic [35:0]        aw;

  logic signed [37:0] p_q;
  logic [15:0]        t2_q;
  logic [15:0]        u_q;
  logic [19:0]        a_q;
  logic [15:0]        t3_q;
  logic [16:0]        w_q;

  // Polynomial terms: (6u - 15) * u and u^2, then a and u^3, then a * u^3.
  always_comb begin
    k6  = $signed(21'(u_i) * 21'd6) - FADE_C15;
    p_d = 38'(k6) * 38'($signed({1'b0, u_i}));
    uu  = 32'(u_i) * 32'(u_i);
    a_d = 21'(p_q >>> 16) + FADE_C10;
    t3w = 32'(t2_q) * 32'(u_q);
    aw  = 36'(a_q) * 36'(t3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      p_q  <= p_d;
      t2_q <= uu[31:16];
      u_q  <= u_i;
    end
    if (en_i[3]) begin
      a_q  <= a_d[19:0];
      t3_q <= t3w[31:16];
    end
    if (en_i[4]) begin
      w_q <= aw[32:16];
    end
  end

  assign w_o = w_q;

endmodule

// ===== src/sgn_hash.sv =====
// Corner hashing of the four cell corners down to their unit gradients.
`timescale 1ns / 1ps
module sgn_hash (
  input  logic                clk_i,
  input  sgn_pkg::stage_en_t  en_i,
  input  logic [31:0]         seed_mix_i,
  input  logic [31:0]         cx_i,
  input  logic [31:0]         cy_i,
  output logic signed [15:0]  gx_o [4],
  output logic signed [15:0]  gy_o [4]
);
  import sgn_pkg::*;

  logic [31:0]        ax_q;
  logic [31:0]        by_q;
  logic [31:0]        x3_q [4];
  logic [31:0]        m4_q [4];
  logic [13:0]        s5_q [4];
  logic [7:0]         q5_q [4];
  logic [2:0]         lo5_q [4];
  logic signed [15:0] gx_q [4];
  logic signed [15:0] gy_q [4];

  logic [31:0] h0   [4];
  logic [31:0] m4_d [4];
  logic [31:0] hf   [4];
  logic [13:0] s5_d [4];
  logic [27:0] qw   [4];
  logic [13:0] r6   [4];
  logic [8:0]  ang  [4];
  logic [9:0]  angc [4];
  logic [8:0]  ang9 [4];

  // Per corner: seed mix and xor-shift, mixing multiply, mod 360, table lookup.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      h0[i]   = ax_q + by_q + seed_mix_i + CORNER_OFS[i];
      m4_d[i] = 32'(64'(x3_q[i]) * 64'(HASH_KMIX));
      hf[i]   = m4_q[i] ^ (m4_q[i] >> 16);
      // 2^12 is 1 modulo 45, so the 12-bit chunks of h/8 sum to the same residue.
      s5_d[i] = 14'(hf[i][14:3]) + 14'(hf[i][26:15]) + 14'(hf[i][31:27]);
      qw[i]   = 28'(s5_d[i]) * 28'(MOD45_RECIP);
      r6[i]   = s5_q[i] - 14'(q5_q[i] * 14'd45);
      ang[i]  = {r6[i][5:0], lo5_q[i]};
      angc[i] = 10'(ang[i]) + 10'd90;
      ang9[i] = (angc[i] >= 10'd360) ? 9'(angc[i] - 10'd360) : angc[i][8:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ax_q <= 32'(64'(cx_i) * 64'(HASH_KX));
      by_q <= 32'(64'(cy_i) * 64'(HASH_KY));
    end
    for (int i = 0; i < 4; i++) begin
      if (en_i[3]) begin
        x3_q[i] <= h0[i] ^ (h0[i] >> 13);
      end
      if (en_i[4]) begin
        m4_q[i] <= m4_d[i];
      end
      if (en_i[5]) begin
        s5_q[i]  <= s5_d[i];
        q5_q[i]  <= qw[i][MOD45_SHIFT +: 8];
        lo5_q[i] <= hf[i][2:0];
      end
      if (en_i[6]) begin
        gx_q[i] <= sin_deg(ang9[i]);
        gy_q[i] <= sin_deg(ang[i]);
      end
    end
  end

  assign gx_o = gx_q;
  assign gy_o = gy_q;

endmodule

// ===== src/sgn_blend.sv =====
// Corner dot products, blends weighted by the x fade and then the y fade, rounding and saturation.
`timescale 1ns / 1ps
module sgn_blend #(
  parameter int unsigned OUT_FRAC_BITS = sgn_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  sgn_pkg::stage_en_t  en_i,
  input  logic signed [15:0]  gx_i [4],
  input  logic signed [15:0]  gy_i [4],
  input  logic [15:0]         ux_i,
  input  logic [15:0]         uy_i,
  input  logic [16:0]         wx_i,
  input  logic [16:0]         wy_i,
  output logic signed [15:0]  noise_o
);
  import sgn_pkg::*;

  localparam int unsigned SH = 16 - OUT_FRAC_BITS;
  localparam logic signed [19:0] RND = 20'sd1 <<< (SH - 1);

  logic signed [17:0] dx [4];
  logic signed [17:0] dy [4];
  logic signed [34:0] dsum [4];
  logic signed [19:0] dd0, dd1, ry;
  logic signed [18:0] v12;
  logic signed [19:0] rnd;

  logic signed [33:0] pa_q [4];
  logic signed [33:0] pb_q [4];
  logic signed [18:0] d_q  [4];
  logic signed [37:0] m0_q, m1_q, my_q;
  logic signed [18:0] d0_q, d2_q, r0_q, r1_q, r0b_q;
  logic [16:0]        wx7_q, wx8_q, wy7_q, wy8_q, wy9_q, wy10_q;
  logic signed [15:0] out_q;

  // Offsets from the corners: u and u - 1 along each axis.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dx[i]   = i[0] ? $signed({2'b0, ux_i}) - ONE_Q16 : $signed({2'b0, ux_i});
      dy[i]   = i[1] ? $signed({2'b0, uy_i}) - ONE_Q16 : $signed({2'b0, uy_i});
      dsum[i] = 35'(pa_q[i]) + 35'(pb_q[i]) + DOT_ROUND;
    end
    dd0 = 20'(d_q[1]) - 20'(d_q[0]);
    dd1 = 20'(d_q[3]) - 20'(d_q[2]);
    ry  = 20'(r1_q) - 20'(r0_q);
    v12 = r0b_q + 19'(my_q >>> 16);
    rnd = (20'(v12) + RND) >>> SH;
  end

  always_ff @(posedge clk_i) begin
    // Stage 7: gradient times offset.
    if (en_i[7]) begin
      for (int i = 0; i < 4; i++) begin
        pa_q[i] <= 34'(dx[i]) * 34'(gx_i[i]);
        pb_q[i] <= 34'(dy[i]) * 34'(gy_i[i]);
      end
      wx7_q <= wx_i;
      wy7_q <= wy_i;
    end
    // Stage 8: dot product rounded to Q.16.
    if (en_i[8]) begin
      for (int i = 0; i < 4; i++) begin
        d_q[i] <= 19'(dsum[i] >>> 14);
      end
      wx8_q <= wx7_q;
      wy8_q <= wy7_q;
    end
    // Stage 9: difference along x times the x weight.
    if (en_i[9]) begin
      m0_q  <= 38'(dd0) * 38'($signed({1'b0, wx8_q}));
      m1_q  <= 38'(dd1) * 38'($signed({1'b0, wx8_q}));
      d0_q  <= d_q[0];
      d2_q  <= d_q[2];
      wy9_q <= wy8_q;
    end
    // Stage 10: both rows blended.
    if (en_i[10]) begin
      r0_q   <= d0_q + 19'(m0_q >>> 16);
      r1_q   <= d2_q + 19'(m1_q >>> 16);
      wy10_q <= wy9_q;
    end
    // Stage 11: difference along y times the y weight.
    if (en_i[11]) begin
      my_q  <= 38'(ry) * 38'($signed({1'b0, wy10_q}));
      r0b_q <= r0_q;
    end
    // Stage 12: final blend, rounding and saturation into the output register.
    if (en_i[12]) begin
      if (rnd > 20'sd32767) begin
        out_q <= 16'sh7FFF;
      end else if (rnd < -20'sd32768) begin
        out_q <= 16'sh8000;
      end else begin
        out_q <= rnd[15:0];
      end
    end
  end

  assign noise_o = out_q;

endmodule

// ===== src/seeded_gradient_noise_2d.sv =====
// Top level of the seeded 2-D gradient noise pipeline.
`timescale 1ns / 1ps
// Usage:
//   Input channel: in_valid_i with x_coord_i and y_coord_i (signed fixed point with
//   COORD_FRAC_BITS fraction bits); a request is taken when in_valid_i is high and
//   in_stall_o is low.
//   Output channel: out_valid_o with noise_value_o (signed, OUT_FRAC_BITS fraction
//   bits, saturated); a request is delivered when out_valid_o is high and
//   out_stall_i is low.
//   Seed port: cfg_valid_i with cfg_data_i; cfg_ready_o is always high and the seed
//   is written at once. Write it only while the pipeline is empty.
//   Pipeline: an accepted request enters stage 1 and moves through stages 2 to 12;
//   out_valid_o is the valid bit of stage 12. Throughput is one sample per cycle
//   while the receiver does not stall; the pipeline has twelve register stages of
//   cell split, hashing, fade, dot products and blends.
//   Reset empties the pipeline and sets the seed to 123456789.
//   When the receiver stalls, the result holds in the output register and earlier
//   stages keep filling any empty slots; in_stall_o rises only once every stage
//   ahead of the input holds a sample.
module seeded_gradient_noise_2d #(
  parameter int unsigned COORD_FRAC_BITS = sgn_pkg::COORD_FRAC_BITS_DEF,
  parameter int unsigned OUT_FRAC_BITS   = sgn_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] noise_value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);
  import sgn_pkg::*;

  localparam logic [31:0] FRAC_MASK = (32'd1 << COORD_FRAC_BITS) - 32'd1;

  logic [NUM_STAGES:1] v_q;
  logic [NUM_STAGES:0] v_in;
  stage_en_t           en;

  logic [31:0] seed_q, seed_mix_q;
  logic [31:0] cx_d, cy_d, cx_q, cy_q;
  logic [47:0] fx, fy;
  logic [15:0] ux_q [1:6];
  logic [15:0] uy_q [1:6];
  logic [16:0] wx, wy, wx5_q, wy5_q, wx6_q, wy6_q;
  logic signed [15:0] gx [4];
  logic signed [15:0] gy [4];

  // Stage enables: a stage loads when it is empty or the one after it moves.
  always_comb begin
    v_in = {v_q, in_valid_i};
    en[NUM_STAGES] = !v_q[NUM_STAGES] || !out_stall_i;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k + 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k - 1];
        end
      end
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = v_q[NUM_STAGES];
  assign cfg_ready_o = 1'b1;

  // Seed register and its product with the hash seed multiplier.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q     <= SEED_RESET;
      seed_mix_q <= SEED_MIX_RESET;
    end else begin
      if (cfg_valid_i) begin
        seed_q <= cfg_data_i;
      end
      seed_mix_q <= 32'(64'(seed_q) * 64'(HASH_KS));
    end
  end

  // Stage 1: floor cell and fraction rescaled to Q0.16.
  always_comb begin
    cx_d = 32'(x_coord_i >>> COORD_FRAC_BITS);
    cy_d = 32'(y_coord_i >>> COORD_FRAC_BITS);
    fx   = ({16'b0, 32'(x_coord_i) & FRAC_MASK} << 16) >> COORD_FRAC_BITS;
    fy   = ({16'b0, 32'(y_coord_i) & FRAC_MASK} << 16) >> COORD_FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      ux_q[1] <= fx[15:0];
      uy_q[1] <= fy[15:0];
    end
    for (int k = 2; k <= 6; k++) begin
      if (en[k]) begin
        ux_q[k] <= ux_q[k - 1];
        uy_q[k] <= uy_q[k - 1];
      end
    end
    if (en[5]) begin
      wx5_q <= wx;
      wy5_q <= wy;
    end
    if (en[6]) begin
      wx6_q <= wx5_q;
      wy6_q <= wy5_q;
    end
  end

  sgn_hash u_hash (
    .clk_i      (clk_i),
    .en_i       (en),
    .seed_mix_i (seed_mix_q),
    .cx_i       (cx_q),
    .cy_i       (cy_q),
    .gx_o       (gx),
    .gy_o       (gy)
  );

  sgn_fade u_fade_x (
    .clk_i (clk_i),
    .en_i  (en),
    .u_i   (ux_q[1]),
    .w_o   (wx)
  );

  sgn_fade u_fade_y (
    .clk_i (clk_i),
    .en_i  (en),
    .u_i   (uy_q[1]),
    .w_o   (wy)
  );

  sgn_blend #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_blend (
    .clk_i   (clk_i),
    .en_i    (en),
    .gx_i    (gx),
    .gy_i    (gy),
    .ux_i    (ux_q[6]),
    .uy_i    (uy_q[6]),
    .wx_i    (wx6_q),
    .wy_i    (wy6_q),
    .noise_o (noise_value_o)
  );

  // An accepted request always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[1])
    else $error("accepted request not captured in stage 1");

  // Without a stall at the output every stage advances.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output flows");

  // The input stalls only when every stage holds a sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with an empty stage");

  // A seed write reaches seed_q on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> seed_q == $past(cfg_data_i))
    else $error("seed write lost");

endmodule
